// ===== rtl/core/sacs_pkg.sv =====
// ----------------------------------------------------------------------------
// sacs_pkg: shared types and constants of the two-register stack processor
// Memory geometry, item and instruction codes, result status codes, and the
// packed words that travel on the request, result and control interfaces.
// ----------------------------------------------------------------------------
package sacs_pkg;

   // Word memory; the size is a power of two so an address wraps by its low bits
   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   localparam int WORD_W    = 32;
   localparam int ADDR_W    = 12;
   localparam int CODE_W    = 8;
   localparam int OPR_W     = 24;

   localparam logic [ADDR_W-1:0] STACK_TOP_RESET = ADDR_W'(4095);

   // Item kinds carried in the request opcode field
   typedef enum logic [1:0] {
      ITEM_WRITE = 2'd0,
      ITEM_READ  = 2'd1,
      ITEM_EXEC  = 2'd2,
      ITEM_START = 2'd3
   } sacs_item_type;

   // Result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_HALTED  = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   // Instruction codes
   localparam logic [CODE_W-1:0] CODE_LDC    = 8'd0;
   localparam logic [CODE_W-1:0] CODE_ADC    = 8'd1;
   localparam logic [CODE_W-1:0] CODE_LDL    = 8'd2;
   localparam logic [CODE_W-1:0] CODE_STL    = 8'd3;
   localparam logic [CODE_W-1:0] CODE_LDNL   = 8'd4;
   localparam logic [CODE_W-1:0] CODE_STNL   = 8'd5;
   localparam logic [CODE_W-1:0] CODE_ADD    = 8'd6;
   localparam logic [CODE_W-1:0] CODE_SUB    = 8'd7;
   localparam logic [CODE_W-1:0] CODE_SHL    = 8'd8;
   localparam logic [CODE_W-1:0] CODE_SHR    = 8'd9;
   localparam logic [CODE_W-1:0] CODE_ADJ    = 8'd10;
   localparam logic [CODE_W-1:0] CODE_A2SP   = 8'd11;
   localparam logic [CODE_W-1:0] CODE_SP2A   = 8'd12;
   localparam logic [CODE_W-1:0] CODE_CALL   = 8'd13;
   localparam logic [CODE_W-1:0] CODE_RETURN = 8'd14;
   localparam logic [CODE_W-1:0] CODE_BRZ    = 8'd15;
   localparam logic [CODE_W-1:0] CODE_BRLZ   = 8'd16;
   localparam logic [CODE_W-1:0] CODE_BR     = 8'd17;
   localparam logic [CODE_W-1:0] CODE_HALT   = 8'd18;

   typedef struct packed {
      logic [1:0]               opcode;
      logic [ADDR_W-1:0]        address;
      logic signed [WORD_W-1:0] write_data;
   } sacs_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] read_data;
      logic signed [WORD_W-1:0] program_counter;
      logic signed [WORD_W-1:0] stack_pointer;
      logic signed [WORD_W-1:0] reg_a;
      logic signed [WORD_W-1:0] reg_b;
      logic [CODE_W-1:0]        executed_code;
      logic signed [OPR_W-1:0]  executed_operand;
      logic [WORD_W-1:0]        instructions_done;
   } sacs_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;
      logic issue;
      logic finish_item;
      logic decode;
      logic execute;
   } sacs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic stopped;
   } sacs_stat_type;

   function automatic logic [MEM_AW-1:0] wrap_addr(input logic [WORD_W-1:0] addr);
      return addr[MEM_AW-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] sext_opr(input logic [OPR_W-1:0] opr);
      return {{(WORD_W-OPR_W){opr[OPR_W-1]}}, opr};
   endfunction

endpackage

// ===== rtl/core/sacs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacs_ctrl: item sequencer
// Runs the memory clearing pass after reset, then steps each accepted item
// through its phases and issues the one-cycle result strobe.
// ----------------------------------------------------------------------------
module sacs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_opcode,
   input  sacs_pkg::sacs_stat_type stat,
   output sacs_pkg::sacs_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import sacs_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ITEM,
      S_DECODE,
      S_EXECUTE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.clear       = (state_ff == S_CLEAR);
      cmd.issue       = (state_ff == S_IDLE) && start;
      cmd.finish_item = (state_ff == S_ITEM);
      cmd.decode      = (state_ff == S_DECODE);
      cmd.execute     = (state_ff == S_EXECUTE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               if (stat.clear_done) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  // a step while stopped only reports; it skips decode and execute
                  if ((req_opcode == ITEM_EXEC) && !stat.stopped) begin
                     state_ff <= S_DECODE;
                  end else begin
                     state_ff <= S_ITEM;
                  end
               end
            end
            S_ITEM: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            S_DECODE: begin
               state_ff <= S_EXECUTE;
            end
            S_EXECUTE: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/sacs_dp.sv =====
// ----------------------------------------------------------------------------
// sacs_dp: processor datapath
// Word memory with one write and one registered read port, the architectural
// registers, the stack top register and the result registers.
// ----------------------------------------------------------------------------
module sacs_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  sacs_pkg::sacs_cmd_type  cmd,
   input  sacs_pkg::sacs_req_type  req_data,
   input  logic                    csr_valid,
   input  logic [sacs_pkg::ADDR_W-1:0] csr_data,
   output sacs_pkg::sacs_stat_type stat,
   output sacs_pkg::sacs_rsp_type  rsp_data
);
   import sacs_pkg::*;

   logic [WORD_W-1:0] mem_words [MEM_WORDS];

   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_re;
   logic [MEM_AW-1:0] mem_raddr;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   logic [MEM_AW-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] stack_top_ff;

   sacs_req_type      req_ff;
   logic [WORD_W-1:0] inst_ff, inst_in;
   logic [MEM_AW-1:0] daddr_ff, daddr_in;

   logic [WORD_W-1:0] pc_ff, pc_in;
   logic [WORD_W-1:0] sp_ff, sp_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic              stopped_ff, stopped_in;
   logic [WORD_W-1:0] count_ff, count_in;

   logic [1:0]        status_ff, status_in;
   logic [WORD_W-1:0] rdata_ff, rdata_in;
   logic [CODE_W-1:0] xcode_ff, xcode_in;
   logic [OPR_W-1:0]  xopr_ff, xopr_in;

   logic [CODE_W-1:0] code_w;
   logic [WORD_W-1:0] opr_w;
   logic [WORD_W-1:0] pc_inc;
   logic [WORD_W-1:0] pc_rel;
   logic [WORD_W-1:0] dec_base;

   assign code_w = inst_ff[CODE_W-1:0];
   assign opr_w  = sext_opr(inst_ff[WORD_W-1:CODE_W]);
   assign pc_inc = pc_ff + WORD_W'(1);
   assign pc_rel = pc_inc + opr_w;

   assign stat.clear_done = (clr_cnt_ff == MEM_AW'(MEM_WORDS - 1));
   assign stat.stopped    = stopped_ff;

   // Data address for local and non-local accesses, from the fetched word
   always_comb begin
      if ((rd_data_ff[CODE_W-1:0] == CODE_LDL) || (rd_data_ff[CODE_W-1:0] == CODE_STL)) begin
         dec_base = sp_ff;
      end else begin
         dec_base = a_ff;
      end
      daddr_in = wrap_addr(dec_base + sext_opr(rd_data_ff[WORD_W-1:CODE_W]));
      inst_in  = rd_data_ff;
   end

   // Memory port selection
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = wrap_addr(pc_ff);
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      if (cmd.issue) begin
         // read the item word, or fetch the instruction at PC
         mem_re = 1'b1;
         if (req_data.opcode == ITEM_READ) begin
            mem_raddr = wrap_addr(WORD_W'(req_data.address));
         end
      end else if (cmd.decode) begin
         mem_re    = 1'b1;
         mem_raddr = daddr_in;
      end
      if (cmd.clear) begin
         mem_we = 1'b1;
      end else if (cmd.finish_item && (req_ff.opcode == ITEM_WRITE)) begin
         mem_we    = 1'b1;
         mem_waddr = wrap_addr(WORD_W'(req_ff.address));
         mem_wdata = req_ff.write_data;
      end else if (cmd.execute && (code_w == CODE_STL)) begin
         mem_we    = 1'b1;
         mem_waddr = daddr_ff;
         mem_wdata = a_ff;
      end else if (cmd.execute && (code_w == CODE_STNL)) begin
         mem_we    = 1'b1;
         mem_waddr = daddr_ff;
         mem_wdata = b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_words[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_words[mem_raddr];
      end
   end

   // Next architectural and result state
   always_comb begin
      pc_in      = pc_ff;
      sp_in      = sp_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      stopped_in = stopped_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      rdata_in   = rdata_ff;
      xcode_in   = xcode_ff;
      xopr_in    = xopr_ff;
      if (cmd.finish_item) begin
         status_in = ST_DONE;
         rdata_in  = '0;
         xcode_in  = '0;
         xopr_in   = '0;
         case (sacs_item_type'(req_ff.opcode))
            ITEM_READ: begin
               rdata_in = rd_data_ff;
            end
            ITEM_START: begin
               pc_in      = '0;
               sp_in      = WORD_W'(stack_top_ff);
               a_in       = '0;
               b_in       = '0;
               count_in   = '0;
               stopped_in = 1'b0;
            end
            ITEM_EXEC: begin
               status_in = ST_IGNORED;
            end
            default: begin
            end
         endcase
      end else if (cmd.execute) begin
         status_in = ST_DONE;
         rdata_in  = '0;
         xcode_in  = code_w;
         xopr_in   = inst_ff[WORD_W-1:CODE_W];
         if (code_w == CODE_HALT) begin
            stopped_in = 1'b1;
            status_in  = ST_HALTED;
         end else if (code_w > CODE_HALT) begin
            stopped_in = 1'b1;
            status_in  = ST_INVALID;
         end else begin
            pc_in = pc_inc;
            if (count_ff != '1) begin
               count_in = count_ff + WORD_W'(1);
            end
            unique case (code_w)
               CODE_LDC: begin
                  b_in = a_ff;
                  a_in = opr_w;
               end
               CODE_ADC:  a_in = a_ff + opr_w;
               CODE_LDL: begin
                  b_in = a_ff;
                  a_in = rd_data_ff;
               end
               CODE_STL:  a_in = b_ff;
               CODE_LDNL: a_in = rd_data_ff;
               CODE_STNL: begin
               end
               CODE_ADD:  a_in = a_ff + b_ff;
               CODE_SUB:  a_in = b_ff - a_ff;
               CODE_SHL: begin
                  // amounts past 31 shift everything out
                  if (|a_ff[WORD_W-1:5]) begin
                     a_in = '0;
                  end else begin
                     a_in = b_ff << a_ff[4:0];
                  end
               end
               CODE_SHR: begin
                  if (|a_ff[WORD_W-1:5]) begin
                     a_in = {WORD_W{b_ff[WORD_W-1]}};
                  end else begin
                     a_in = WORD_W'($signed(b_ff) >>> a_ff[4:0]);
                  end
               end
               CODE_ADJ:  sp_in = sp_ff + opr_w;
               CODE_A2SP: begin
                  sp_in = a_ff;
                  a_in  = b_ff;
               end
               CODE_SP2A: begin
                  b_in = a_ff;
                  a_in = sp_ff;
               end
               CODE_CALL: begin
                  b_in  = a_ff;
                  a_in  = pc_inc;
                  pc_in = pc_rel;
               end
               CODE_RETURN: begin
                  pc_in = a_ff;
                  a_in  = b_ff;
               end
               CODE_BRZ: begin
                  if (a_ff == '0) begin
                     pc_in = pc_rel;
                  end
               end
               CODE_BRLZ: begin
                  if (a_ff[WORD_W-1]) begin
                     pc_in = pc_rel;
                  end
               end
               CODE_BR:   pc_in = pc_rel;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         stack_top_ff <= STACK_TOP_RESET;
         pc_ff        <= '0;
         sp_ff        <= WORD_W'(STACK_TOP_RESET);
         a_ff         <= '0;
         b_ff         <= '0;
         stopped_ff   <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + MEM_AW'(1);
         end
         if (csr_valid) begin
            stack_top_ff <= csr_data;
         end
         pc_ff      <= pc_in;
         sp_ff      <= sp_in;
         a_ff       <= a_in;
         b_ff       <= b_in;
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         req_ff <= req_data;
      end
      if (cmd.decode) begin
         inst_ff  <= inst_in;
         daddr_ff <= daddr_in;
      end
      status_ff <= status_in;
      rdata_ff  <= rdata_in;
      xcode_ff  <= xcode_in;
      xopr_ff   <= xopr_in;
   end

   always_comb begin
      rsp_data                   = '0;
      rsp_data.status            = status_ff;
      rsp_data.read_data         = rdata_ff;
      rsp_data.program_counter   = pc_ff;
      rsp_data.stack_pointer     = sp_ff;
      rsp_data.reg_a             = a_ff;
      rsp_data.reg_b             = b_ff;
      rsp_data.executed_code     = xcode_ff;
      rsp_data.executed_operand  = xopr_ff;
      rsp_data.instructions_done = count_ff;
   end

endmodule

// ===== rtl/core/stack_accumulator_cpu_step_core.sv =====
// ----------------------------------------------------------------------------
// stack_accumulator_cpu_step_core: two-register stack processor, one item per command
// Drive req_data and raise start; the item is taken at an edge where busy is
// low. Items write a memory word, read a memory word, start a run, or execute
// one instruction from the 4096-word memory.
// Each item yields one result word on rsp_data, shown for exactly one cycle
// with rsp_valid high; the receiver cannot stall it, so capture it then.
// From the accepting edge, write, read, start and a step while stopped pass
// through the item state to the strobe; an executed instruction passes through
// decode and then execute, following the three passes through the single memory:
// instruction fetch, data read, then data write. busy is low again in the strobe
// cycle, so the next item can be taken there.
// The stack top register is written on the csr_ channel; csr_ready is always
// high and a write takes effect at the next start-run item.
// After reset the memory is cleared, one word a cycle, with busy high; the
// registers come up as after a start with stack top 4095.
// ----------------------------------------------------------------------------
module stack_accumulator_cpu_step_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  sacs_pkg::sacs_req_type      req_data,
   output logic                        rsp_valid,
   output sacs_pkg::sacs_rsp_type      rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sacs_pkg::ADDR_W-1:0] csr_data
);
   import sacs_pkg::*;

   sacs_cmd_type  cmd;
   sacs_stat_type stat;

   assign csr_ready = 1'b1;

   sacs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_data.opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   sacs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/sacs_check.sv =====
// ----------------------------------------------------------------------------
// sacs_check: port-level checks of the processor's command and result timing
// Watches start, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module sacs_check (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted word occupies the block for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted word");

   // no result the cycle after an accept
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result strobe right after an accepted word");

   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // a result closes work: busy before, idle during the strobe
   a_rsp_ends_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe not at the end of an item");

endmodule

bind stack_accumulator_cpu_step_core sacs_check u_sacs_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the two-register stack processor core
// Loads small programs into the word memory, starts runs and steps them one
// instruction at a time, mixed with stray memory reads and writes. A shadow
// copy of the processor state works out every result word, and a checker
// compares each strobed result field by field, in order. The stack top
// register is changed between phases, including its extremes.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sacs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   sacs_req_type req_data;
   logic         rsp_valid;
   sacs_rsp_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [ADDR_W-1:0] csr_data;

   // Shadow processor state
   logic [WORD_W-1:0] shadow_mem [MEM_WORDS];
   logic [WORD_W-1:0] shadow_pc, shadow_sp, shadow_a, shadow_b, shadow_count;
   logic              shadow_stopped;
   logic [ADDR_W-1:0] shadow_stack_top;

   sacs_rsp_type expected_results [$];
   sacs_rsp_type oldest_result;
   int           error_count = 0;
   int           item_count = 0;
   int           cycle_count = 0;
   int           idle_pct = 0;
   bit           allow_idle = 1'b1;

   stack_accumulator_cpu_step_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] encode_inst(input logic [CODE_W-1:0] code,
                                                     input int opr);
      return {opr[OPR_W-1:0], code};
   endfunction

   function automatic logic [WORD_W-1:0] random_instruction();
      logic [CODE_W-1:0] code;
      logic [OPR_W-1:0]  opr;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 86)
         code = CODE_W'($urandom_range(0, 17));
      else if (pick < 93)
         code = CODE_HALT;
      else
         code = CODE_W'($urandom_range(19, 255));
      // keep most operands small so branches and stack offsets stay near
      if ($urandom_range(0, 9) < 7)
         opr = OPR_W'(int'($urandom_range(0, 16)) - 8);
      else
         opr = OPR_W'($urandom);
      return {opr, code};
   endfunction

   function automatic sacs_rsp_type predict_cpu_result(input sacs_req_type item);
      sacs_rsp_type      res;
      logic [WORD_W-1:0] word, opr, ea;
      logic [CODE_W-1:0] code;
      logic signed [WORD_W-1:0] b_signed;
      res = '0;
      case (sacs_item_type'(item.opcode))
         ITEM_WRITE: shadow_mem[item.address] = item.write_data;
         ITEM_READ:  res.read_data = shadow_mem[item.address];
         ITEM_START: begin
            shadow_pc      = '0;
            shadow_sp      = {{(WORD_W-ADDR_W){1'b0}}, shadow_stack_top};
            shadow_a       = '0;
            shadow_b       = '0;
            shadow_count   = '0;
            shadow_stopped = 1'b0;
         end
         default: begin
            if (shadow_stopped) begin
               res.status = ST_IGNORED;
            end else begin
               word = shadow_mem[shadow_pc[MEM_AW-1:0]];
               code = word[CODE_W-1:0];
               opr  = {{(WORD_W-OPR_W){word[WORD_W-1]}}, word[WORD_W-1:CODE_W]};
               res.executed_code    = code;
               res.executed_operand = word[WORD_W-1:CODE_W];
               if (code == CODE_HALT) begin
                  shadow_stopped = 1'b1;
                  res.status     = ST_HALTED;
               end else if (code > CODE_HALT) begin
                  shadow_stopped = 1'b1;
                  res.status     = ST_INVALID;
               end else begin
                  shadow_pc = shadow_pc + 1;
                  case (code)
                     CODE_LDC: begin
                        shadow_b = shadow_a;
                        shadow_a = opr;
                     end
                     CODE_ADC: shadow_a = shadow_a + opr;
                     CODE_LDL: begin
                        ea       = shadow_sp + opr;
                        shadow_b = shadow_a;
                        shadow_a = shadow_mem[ea[MEM_AW-1:0]];
                     end
                     CODE_STL: begin
                        ea = shadow_sp + opr;
                        shadow_mem[ea[MEM_AW-1:0]] = shadow_a;
                        shadow_a = shadow_b;
                     end
                     CODE_LDNL: begin
                        ea       = shadow_a + opr;
                        shadow_a = shadow_mem[ea[MEM_AW-1:0]];
                     end
                     CODE_STNL: begin
                        ea = shadow_a + opr;
                        shadow_mem[ea[MEM_AW-1:0]] = shadow_b;
                     end
                     CODE_ADD: shadow_a = shadow_a + shadow_b;
                     CODE_SUB: shadow_a = shadow_b - shadow_a;
                     CODE_SHL: begin
                        if (shadow_a > 31)
                           shadow_a = '0;
                        else
                           shadow_a = shadow_b << shadow_a[4:0];
                     end
                     CODE_SHR: begin
                        b_signed = shadow_b;
                        if (shadow_a > 31)
                           shadow_a = {WORD_W{shadow_b[WORD_W-1]}};
                        else
                           shadow_a = b_signed >>> shadow_a[4:0];
                     end
                     CODE_ADJ: shadow_sp = shadow_sp + opr;
                     CODE_A2SP: begin
                        shadow_sp = shadow_a;
                        shadow_a  = shadow_b;
                     end
                     CODE_SP2A: begin
                        shadow_b = shadow_a;
                        shadow_a = shadow_sp;
                     end
                     CODE_CALL: begin
                        shadow_b  = shadow_a;
                        shadow_a  = shadow_pc;
                        shadow_pc = shadow_pc + opr;
                     end
                     CODE_RETURN: begin
                        shadow_pc = shadow_a;
                        shadow_a  = shadow_b;
                     end
                     CODE_BRZ:  if (shadow_a == '0) shadow_pc = shadow_pc + opr;
                     CODE_BRLZ: if (shadow_a[WORD_W-1]) shadow_pc = shadow_pc + opr;
                     CODE_BR:   shadow_pc = shadow_pc + opr;
                     default: ;
                  endcase
                  if (shadow_count != '1) shadow_count = shadow_count + 1;
               end
            end
         end
      endcase
      res.program_counter   = shadow_pc;
      res.stack_pointer     = shadow_sp;
      res.reg_a             = shadow_a;
      res.reg_b             = shadow_b;
      res.instructions_done = shadow_count;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // Compare each strobed result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            oldest_result = expected_results.pop_front();
            check_field("status", oldest_result.status, rsp_data.status);
            check_field("read_data", oldest_result.read_data, rsp_data.read_data);
            check_field("program_counter", oldest_result.program_counter,
                        rsp_data.program_counter);
            check_field("stack_pointer", oldest_result.stack_pointer,
                        rsp_data.stack_pointer);
            check_field("reg_a", oldest_result.reg_a, rsp_data.reg_a);
            check_field("reg_b", oldest_result.reg_b, rsp_data.reg_b);
            check_field("executed_code", oldest_result.executed_code,
                        rsp_data.executed_code);
            check_field("executed_operand", oldest_result.executed_operand,
                        rsp_data.executed_operand);
            check_field("instructions_done", oldest_result.instructions_done,
                        rsp_data.instructions_done);
         end
      end
   end

   // Called at the edge that took the previous word (or with start low);
   // start is only raised or kept here, and lowered only for a gap.
   task automatic send_item(input sacs_item_type kind, input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] data);
      sacs_req_type item;
      int           gap;
      item.opcode     = kind;
      item.address    = addr;
      item.write_data = data;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
         gap = $urandom_range(1, 5);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      item_count++;
      expected_results.push_back(predict_cpu_result(item));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_stack_top(input logic [ADDR_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_stack_top = value;
   endtask

   task automatic run_program_episode();
      int len, steps, i;
      len = $urandom_range(4, 14);
      for (i = 0; i < len; i++)
         send_item(ITEM_WRITE, ADDR_W'(i), random_instruction());
      repeat ($urandom_range(0, 2))
         send_item(ITEM_WRITE, ADDR_W'($urandom), $urandom);
      send_item(ITEM_START, ADDR_W'($urandom), $urandom);
      steps = $urandom_range(len, 3 * len);
      repeat (steps) begin
         // stray memory traffic in the middle of a run
         if ($urandom_range(0, 9) == 0)
            send_item(sacs_item_type'($urandom_range(0, 1)), ADDR_W'($urandom), $urandom);
         send_item(ITEM_EXEC, ADDR_W'($urandom), $urandom);
      end
   endtask

   task automatic run_noise_episode();
      repeat ($urandom_range(5, 15))
         send_item(sacs_item_type'($urandom_range(0, 3)), ADDR_W'($urandom), $urandom);
   endtask

   task automatic run_episodes(input int quota);
      int goal;
      goal = item_count + quota;
      while (item_count < goal) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
         endcase
         if (!allow_idle) idle_pct = 0;
         if ($urandom_range(0, 5) == 0)
            run_noise_episode();
         else
            run_program_episode();
      end
   endtask

   task automatic test_reset_state();
      idle_pct = 30;
      send_item(ITEM_READ, 12'hFFF, '0);
      // cleared memory decodes as a load of zero, run from the reset state
      send_item(ITEM_EXEC, '0, '0);
      send_item(ITEM_WRITE, 12'hFFF, 32'h8000_0000);
      send_item(ITEM_READ, 12'hFFF, '0);
   endtask

   task automatic test_special_cases();
      send_item(ITEM_WRITE, 12'd0, encode_inst(CODE_LDC, -5));
      send_item(ITEM_WRITE, 12'd1, encode_inst(CODE_LDC, 40));
      send_item(ITEM_WRITE, 12'd2, encode_inst(CODE_SHR, 0));
      send_item(ITEM_WRITE, 12'd3, encode_inst(CODE_LDC, 33));
      send_item(ITEM_WRITE, 12'd4, encode_inst(CODE_SHL, 0));
      // stack top plus one wraps to word 0, minus one reaches word 4094
      send_item(ITEM_WRITE, 12'd5, encode_inst(CODE_LDL, 1));
      send_item(ITEM_WRITE, 12'd6, encode_inst(CODE_LDL, -1));
      send_item(ITEM_WRITE, 12'd7, encode_inst(CODE_ADC, 1));
      send_item(ITEM_WRITE, 12'd8, encode_inst(8'hFF, -1));
      send_item(ITEM_WRITE, 12'hFFE, 32'h7FFF_FFFF);
      send_item(ITEM_START, '0, '0);
      repeat (10) send_item(ITEM_EXEC, '0, '0);
      send_item(ITEM_WRITE, 12'd0, encode_inst(CODE_HALT, 0));
      send_item(ITEM_START, '0, '0);
      send_item(ITEM_EXEC, '0, '0);
      send_item(ITEM_EXEC, '0, '0);
   endtask

   task automatic test_stack_top_settings();
      logic [ADDR_W-1:0] settings [4];
      int                k;
      settings = '{12'd0, 12'hFFF, ADDR_W'($urandom), 12'd7};
      for (k = 0; k < 4; k++) begin
         write_stack_top(settings[k]);
         run_episodes(330);
      end
   endtask

   task automatic test_full_rate();
      allow_idle = 1'b0;
      idle_pct   = 0;
      write_stack_top(ADDR_W'($urandom));
      run_episodes(300);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
      shadow_stack_top = STACK_TOP_RESET;
      shadow_pc        = '0;
      shadow_sp        = {{(WORD_W-ADDR_W){1'b0}}, STACK_TOP_RESET};
      shadow_a         = '0;
      shadow_b         = '0;
      shadow_count     = '0;
      shadow_stopped   = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_special_cases();
      test_stack_top_settings();
      test_full_rate();
      drain_results();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sacs_pkg.sv
rtl/core/sacs_ctrl.sv
rtl/core/sacs_dp.sv
rtl/core/stack_accumulator_cpu_step_core.sv
rtl/core/sacs_check.sv
tb/tb_top.sv
